// ===== rtl/core/fvad_pkg.sv =====
// Shared types and constants for the frame voice activity detector.
// Used by fvad_ctrl, fvad_datapath and frame_voice_activity_detector.
package fvad_pkg;

  // Sample format
  localparam int unsigned SAMPLE_BITS = 16;

  // Configuration register widths and reset values
  localparam int unsigned THR_W = 31;
  localparam int unsigned FLEN_W = 11;
  localparam int unsigned SRATE_W = 17;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [THR_W-1:0] THR_RESET = 31'd1073742;
  localparam logic [FLEN_W-1:0] FLEN_RESET = 11'd512;
  localparam logic [SRATE_W-1:0] SRATE_RESET = 17'd16000;

  // Centroid test: 2 * 1000 Hz on the right-hand side of the cross product
  localparam int unsigned CENTROID_SCALE = 2000;
  localparam int unsigned CENTROID_SCALE_W = 11;

  // Hangover run lengths
  localparam logic [1:0] VOICED_FRAMES = 2'd3;
  localparam logic [2:0] SILENT_FRAMES = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENERGY_THRESHOLD = 2'd0,
    CFG_FRAME_LENGTH     = 2'd1,
    CFG_SAMPLE_RATE      = 2'd2
  } fvad_cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_frame;
  } fvad_in_t;

  typedef struct packed {
    logic voice_active;
    logic raw_detection;
    logic length_error;
  } fvad_out_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_MUL1,
    ST_MUL2,
    ST_CMP,
    ST_DONE
  } fvad_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accumulate;
    logic mul1;
    logic mul2;
    logic compare;
    logic finish;
  } fvad_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic len_ok;
  } fvad_sts_t;

endpackage

// ===== rtl/core/fvad_ctrl.sv =====
// Frame sequencer for the voice activity detector: accumulate, evaluate, emit.
// Depends on fvad_pkg for the state, command and status types.
module fvad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fvad_pkg::fvad_sts_t sts_i,
  output fvad_pkg::fvad_cmd_t cmd_o
);

  fvad_pkg::fvad_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic in_xfer;
  logic out_free;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fvad_pkg::ST_ACCUM: begin
        if (in_xfer && in_last_i) state_d = fvad_pkg::ST_MUL1;
      end
      fvad_pkg::ST_MUL1: begin
        state_d = sts_i.len_ok ? fvad_pkg::ST_MUL2 : fvad_pkg::ST_DONE;
      end
      fvad_pkg::ST_MUL2: state_d = fvad_pkg::ST_CMP;
      fvad_pkg::ST_CMP:  state_d = fvad_pkg::ST_DONE;
      fvad_pkg::ST_DONE: begin
        if (out_free) state_d = fvad_pkg::ST_ACCUM;
      end
      default: state_d = fvad_pkg::ST_ACCUM;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready_o         = 1'b0;
    cmd_o              = '0;
    unique case (state_q)
      fvad_pkg::ST_ACCUM: begin
        in_ready_o       = 1'b1;
        cmd_o.accumulate = in_valid_i;
      end
      fvad_pkg::ST_MUL1: cmd_o.mul1    = 1'b1;
      fvad_pkg::ST_MUL2: cmd_o.mul2    = 1'b1;
      fvad_pkg::ST_CMP:  cmd_o.compare = 1'b1;
      fvad_pkg::ST_DONE: cmd_o.finish  = out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Hold the result valid until the output transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fvad_pkg::ST_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/fvad_datapath.sv =====
// Feature accumulators, frame-end comparisons, hangover and config registers.
// Depends on fvad_pkg; sequenced by fvad_ctrl through fvad_cmd_t.
module fvad_datapath #(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fvad_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fvad_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  fvad_pkg::fvad_in_t                in_data_i,
  input  fvad_pkg::fvad_cmd_t               cmd_i,
  output fvad_pkg::fvad_sts_t               sts_o,
  output fvad_pkg::fvad_out_t               out_data_o
);

  localparam int unsigned SB   = fvad_pkg::SAMPLE_BITS;
  localparam int unsigned KB   = $clog2(MAX_FRAME + 1);
  localparam int unsigned CW   = $clog2(MAX_FRAME + 2);
  localparam int unsigned EW   = 2 * (SB - 1) + KB;
  localparam int unsigned MW   = (SB - 1) + KB;
  localparam int unsigned WW   = (SB - 2) + 2 * KB;
  localparam int unsigned WLO  = (WW + 1) / 2;
  localparam int unsigned WHI  = WW - WLO;
  localparam int unsigned ETW  = fvad_pkg::THR_W + CW;
  localparam int unsigned NMW  = CW + MW;
  localparam int unsigned PLW  = fvad_pkg::SRATE_W + WLO;
  localparam int unsigned PHW  = fvad_pkg::SRATE_W + WHI;
  localparam int unsigned PCW  = fvad_pkg::SRATE_W + WW;
  localparam int unsigned PRW  = NMW + fvad_pkg::CENTROID_SCALE_W;
  localparam int unsigned ECW  = (EW > ETW) ? EW : ETW;
  localparam int unsigned CCW  = (PCW > PRW) ? PCW : PRW;
  localparam int unsigned NW   = (CW > fvad_pkg::FLEN_W) ? CW : fvad_pkg::FLEN_W;

  // Configuration registers
  logic [fvad_pkg::THR_W-1:0]   thr_q;
  logic [fvad_pkg::FLEN_W-1:0]  flen_q;
  logic [fvad_pkg::SRATE_W-1:0] srate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= fvad_pkg::THR_RESET;
      flen_q  <= fvad_pkg::FLEN_RESET;
      srate_q <= fvad_pkg::SRATE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fvad_pkg::CFG_ENERGY_THRESHOLD: thr_q <= cfg_wdata_i[fvad_pkg::THR_W-1:0];
        fvad_pkg::CFG_FRAME_LENGTH:     flen_q <= cfg_wdata_i[fvad_pkg::FLEN_W-1:0];
        fvad_pkg::CFG_SAMPLE_RATE:      srate_q <= cfg_wdata_i[fvad_pkg::SRATE_W-1:0];
        default: begin
          thr_q <= thr_q;
        end
      endcase
    end
  end

  // Sample magnitude and per-sample products
  logic          neg;
  logic [SB-1:0] mag;
  logic [2*SB-1:0] sq;
  logic [CW+SB-1:0] wprod;
  logic          pos_ok;

  logic [CW-1:0] cnt_q;
  logic [EW-1:0] esum_q;
  logic [MW-1:0] msum_q;
  logic [WW-1:0] wsum_q;
  logic [CW-1:0] cross_q;
  logic          sign_q;

  assign neg    = in_data_i.sample[SB-1];
  assign mag    = neg ? SB'(-in_data_i.sample) : SB'(in_data_i.sample);
  assign sq     = (2*SB)'(mag) * (2*SB)'(mag);
  assign wprod  = (CW+SB)'(cnt_q) * (CW+SB)'(mag);
  assign pos_ok = cnt_q < CW'(MAX_FRAME);

  // Accumulate one sample; clear at frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      esum_q  <= '0;
      msum_q  <= '0;
      wsum_q  <= '0;
      cross_q <= '0;
      sign_q  <= 1'b0;
    end else if (cmd_i.finish) begin
      cnt_q   <= '0;
      esum_q  <= '0;
      msum_q  <= '0;
      wsum_q  <= '0;
      cross_q <= '0;
      sign_q  <= 1'b0;
    end else if (cmd_i.accumulate) begin
      if (pos_ok) begin
        esum_q <= esum_q + EW'(sq);
        msum_q <= msum_q + MW'(mag);
        wsum_q <= wsum_q + WW'(wprod);
        if (cnt_q != '0 && neg != sign_q) cross_q <= cross_q + CW'(1);
        sign_q <= neg;
        cnt_q  <= cnt_q + CW'(1);
      end else begin
        cnt_q <= CW'(MAX_FRAME + 1);
      end
    end
  end

  // Frame length check
  assign sts_o.len_ok = (NW'(cnt_q) == NW'(flen_q)) && (cnt_q >= CW'(2))
                        && (cnt_q <= CW'(MAX_FRAME));

  // Frame-end products, two multiply stages
  logic [ETW-1:0] prod_e_q;
  logic [NMW-1:0] nm_q;
  logic [PLW-1:0] pw_lo_q;
  logic [PCW-1:0] sw_q;
  logic [PRW-1:0] prod_c_q;
  logic [PHW-1:0] pw_hi;
  logic           det_q;
  logic           e_ok, z_ok, c_ok;
  logic [CW:0]    cross2;
  logic [CW:0]    n_m1;

  assign pw_hi = PHW'(srate_q) * PHW'(wsum_q[WW-1:WLO]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      prod_e_q <= ETW'(thr_q) * ETW'(cnt_q);
      nm_q     <= NMW'(cnt_q) * NMW'(msum_q);
      pw_lo_q  <= PLW'(srate_q) * PLW'(wsum_q[WLO-1:0]);
    end
    if (cmd_i.mul2) begin
      sw_q     <= PCW'(pw_lo_q) + (PCW'(pw_hi) << WLO);
      prod_c_q <= PRW'(nm_q) * PRW'(fvad_pkg::CENTROID_SCALE);
    end
    if (cmd_i.compare) begin
      det_q <= e_ok && z_ok && c_ok;
    end
  end

  // Cross-multiplied feature tests
  assign cross2 = {cross_q, 1'b0};
  assign n_m1   = {1'b0, cnt_q} - (CW+1)'(1);
  assign e_ok   = ECW'(esum_q) > ECW'(prod_e_q);
  assign z_ok   = cross2 < n_m1;
  assign c_ok   = CCW'(sw_q) > CCW'(prod_c_q);

  // Hangover
  logic [1:0] vrun_q, vrun_d;
  logic [2:0] srun_q, srun_d;
  logic       voice_q, voice_d;

  always_comb begin
    vrun_d  = vrun_q;
    srun_d  = srun_q;
    voice_d = voice_q;
    if (det_q) begin
      if (vrun_q < fvad_pkg::VOICED_FRAMES) vrun_d = vrun_q + 2'd1;
      srun_d = '0;
      if (vrun_d >= fvad_pkg::VOICED_FRAMES) voice_d = 1'b1;
    end else begin
      if (srun_q < fvad_pkg::SILENT_FRAMES) srun_d = srun_q + 3'd1;
      vrun_d = '0;
      if (srun_d >= fvad_pkg::SILENT_FRAMES) voice_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vrun_q  <= '0;
      srun_q  <= '0;
      voice_q <= 1'b0;
    end else if (cmd_i.finish && sts_o.len_ok) begin
      vrun_q  <= vrun_d;
      srun_q  <= srun_d;
      voice_q <= voice_d;
    end
  end

  // Result register; a bad length reports an error and no voice
  fvad_pkg::fvad_out_t res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (sts_o.len_ok) begin
        res_q.voice_active  <= voice_d;
        res_q.raw_detection <= det_q;
        res_q.length_error  <= 1'b0;
      end else begin
        res_q.voice_active  <= 1'b0;
        res_q.raw_detection <= 1'b0;
        res_q.length_error  <= 1'b1;
      end
    end
  end

  assign out_data_o = res_q;

endmodule

// ===== rtl/core/frame_voice_activity_detector.sv =====
// Frame voice activity detector: energy, zero-crossing and centroid tests.
// Throughput: one sample per cycle inside a frame; the input stalls while a frame is evaluated.
// Evaluation: after the last sample the sequencer runs the two multiply stages and the compare stage
// (a length error skips from the first multiply stage to DONE), then registers the result in DONE.
// Reset (rst_ni low, asynchronous): accumulators, hangover and sequencer cleared,
// config registers return to their defaults.
module frame_voice_activity_detector #(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fvad_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fvad_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fvad_pkg::fvad_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fvad_pkg::fvad_out_t             out_data_o
);

  fvad_pkg::fvad_cmd_t cmd;
  fvad_pkg::fvad_sts_t sts;

  // Sequencer
  fvad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_in_frame),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath
  fvad_datapath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // Stall the input after the last sample of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.last_in_frame) |=> !in_ready_o)
    else $error("input not stalled after frame end");

  // A new result appears only from the evaluation sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised while accumulating");

  // A length error carries no decision
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.length_error)
      |-> (!out_data_o.voice_active && !out_data_o.raw_detection))
    else $error("length error with voice decision");
`endif

endmodule

// ===== bench/fvad_frame_checker.sv =====
// Frame checker for the voice activity detector: predicts one decision per frame.
// Watches the config port and both stream channels; depends on fvad_pkg.
module fvad_frame_checker
  import fvad_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  fvad_in_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  fvad_out_t             out_data_i,
  output int                    fail_cnt_o,
  output int                    pending_o,
  output int                    frames_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  longint unsigned thr_q = THR_RESET;
  longint unsigned flen_q = FLEN_RESET;
  longint unsigned srate_q = SRATE_RESET;

  // Frame accumulators
  longint unsigned sample_cnt = 0;
  longint unsigned energy_acc = 0;
  longint unsigned mag_acc = 0;
  longint unsigned wmag_acc = 0;
  longint unsigned cross_cnt = 0;
  logic            prev_neg = 1'b0;

  // Hangover
  int unsigned     voiced_run = 0;
  int unsigned     silent_run = 0;
  logic            voice_on = 1'b0;

  fvad_out_t       decisions_q[$];

  initial begin
    fail_cnt_o = 0;
    pending_o = 0;
    frames_checked_o = 0;
  end

  task automatic clear_frame();
    sample_cnt = 0;
    energy_acc = 0;
    mag_acc = 0;
    wmag_acc = 0;
    cross_cnt = 0;
    prev_neg = 1'b0;
  endtask

  // Decide the frame just closed, update the hangover and queue the decision
  task automatic close_frame();
    fvad_out_t res;
    logic      det;
    res = '0;
    if (sample_cnt != flen_q || sample_cnt < 2 || sample_cnt > MAX_FRAME) begin
      res.length_error = 1'b1;
    end else begin
      det = (energy_acc > thr_q * sample_cnt) &&
            (2 * cross_cnt < sample_cnt - 1) &&
            (srate_q * wmag_acc > CENTROID_SCALE * sample_cnt * mag_acc);
      if (det) begin
        if (voiced_run < VOICED_FRAMES) voiced_run++;
        silent_run = 0;
        if (voiced_run >= VOICED_FRAMES) voice_on = 1'b1;
      end else begin
        if (silent_run < SILENT_FRAMES) silent_run++;
        voiced_run = 0;
        if (silent_run >= SILENT_FRAMES) voice_on = 1'b0;
      end
      res.voice_active = voice_on;
      res.raw_detection = det;
    end
    decisions_q.push_back(res);
    clear_frame();
  endtask

  // Fold one sample into the running sums; frames beyond MAX_FRAME only saturate the count
  task automatic fold_sample(input fvad_in_t item);
    longint unsigned raw;
    longint unsigned mag;
    logic            neg;
    raw = {48'd0, item.sample};
    neg = item.sample[SAMPLE_BITS-1];
    mag = neg ? ((64'd1 << SAMPLE_BITS) - raw) : raw;
    if (sample_cnt < MAX_FRAME) begin
      energy_acc += mag * mag;
      mag_acc += mag;
      wmag_acc += sample_cnt * mag;
      if (sample_cnt > 0 && neg != prev_neg) cross_cnt++;
      prev_neg = neg;
      sample_cnt++;
    end else begin
      sample_cnt = MAX_FRAME + 1;
    end
    if (item.last_in_frame) close_frame();
  endtask

  // Compare one delivered decision with the oldest prediction
  task automatic check_decision(input fvad_out_t got);
    fvad_out_t want;
    if (decisions_q.size() == 0) begin
      $display("%0t: decision with none pending: va=%0b raw=%0b err=%0b",
               $time, got.voice_active, got.raw_detection, got.length_error);
      fail_cnt_o++;
    end else begin
      want = decisions_q.pop_front();
      frames_checked_o++;
      if (got.voice_active !== want.voice_active ||
          got.raw_detection !== want.raw_detection ||
          got.length_error !== want.length_error) begin
        $display("%0t: decision mismatch, expected va=%0b raw=%0b err=%0b,",
                 $time, want.voice_active, want.raw_detection, want.length_error);
        $display("%0t:   got va=%0b raw=%0b err=%0b",
                 $time, got.voice_active, got.raw_detection, got.length_error);
        fail_cnt_o++;
      end
    end
  endtask

  // Track register writes, check results, then fold accepted samples
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q = THR_RESET;
      flen_q = FLEN_RESET;
      srate_q = SRATE_RESET;
      clear_frame();
      voiced_run = 0;
      silent_run = 0;
      voice_on = 1'b0;
      decisions_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (fvad_cfg_idx_e'(cfg_idx_i))
          CFG_ENERGY_THRESHOLD: thr_q = cfg_wdata_i[THR_W-1:0];
          CFG_FRAME_LENGTH:     flen_q = cfg_wdata_i[FLEN_W-1:0];
          CFG_SAMPLE_RATE:      srate_q = cfg_wdata_i[SRATE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_decision(out_data_i);
      if (in_valid_i && in_ready_i) fold_sample(in_data_i);
    end
    pending_o = decisions_q.size();
  end

endmodule

// ===== bench/frame_voice_activity_detector_tb.sv =====
// Top of the voice activity detector bench: clock, reset, sample frames and config writes.
// Instantiates frame_voice_activity_detector and fvad_frame_checker; depends on fvad_pkg.
module frame_voice_activity_detector_tb;
  import fvad_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_FRAME = 1024;
  localparam int RANDOM_ITEMS = 1010;

  typedef enum int {
    FK_VOICE,
    FK_QUIET,
    FK_HISS,
    FK_FADE,
    FK_WILD
  } frame_kind_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  fvad_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  fvad_out_t             out_data;

  int                    fail_cnt;
  int                    pending;
  int                    frames_checked;

  bit                    idle_en = 1'b1;
  int                    samples_sent = 0;
  int                    settings_used = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_voice_activity_detector #(
    .MAX_FRAME(MAX_FRAME)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  fvad_frame_checker #(
    .MAX_FRAME(MAX_FRAME)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending),
    .frames_checked_o(frames_checked)
  );

  // Hold off the output side in short random bursts
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 4);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Drive one sample and hold it until the transaction completes
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.sample = s;
    in_data.last_in_frame = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic pair(input int a, input int b);
    push_sample(16'(a), 1'b0);
    push_sample(16'(b), 1'b1);
  endtask

  // Drop valid, wait for every pending decision, then let the frame-end pipeline empty
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write one register; unused upper data bits sometimes carry noise
  task automatic write_reg(input fvad_cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    logic [31:0] junk;
    junk = $urandom();
    if (junk[31]) begin
      case (idx)
        CFG_FRAME_LENGTH: value[CFG_DATA_W-1:FLEN_W] = junk[CFG_DATA_W-1:FLEN_W];
        CFG_SAMPLE_RATE:  value[CFG_DATA_W-1:SRATE_W] = junk[CFG_DATA_W-1:SRATE_W];
        default: ;
      endcase
    end
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] thr, input int flen, input int srate);
    write_reg(CFG_ENERGY_THRESHOLD, thr);
    write_reg(CFG_FRAME_LENGTH, CFG_DATA_W'(flen));
    write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'(srate));
    settings_used++;
  endtask

  // Send n samples shaped after one kind of audio content
  task automatic send_frame(input int n, input frame_kind_e kind);
    int amp;
    int m;
    bit sgn;
    amp = $urandom_range(6000, 32767);
    sgn = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      case (kind)
        FK_VOICE: begin
          m = $urandom_range(0, 1500);
          m = amp - m;
          if (sgn ^ ($urandom_range(0, 15) == 0)) m = -m;
        end
        FK_QUIET: begin
          m = $urandom_range(0, 8);
          m = m - 4;
        end
        FK_HISS: begin
          m = $urandom_range(2000, 30000);
          if (i % 2) m = -m;
        end
        FK_FADE: m = (i == 0) ? amp : $urandom_range(0, 3);
        default: m = $urandom_range(0, 65535);
      endcase
      push_sample(16'(m), i == n - 1);
    end
  endtask

  initial begin
    int run_left;
    int n;
    int nframes;
    int rand_sent;
    int flen;
    logic [CFG_DATA_W-1:0] thr;
    int srate;
    frame_kind_e kind;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: two-sample frames, field extremes, hangover set and clear, wrong lengths
    set_config('0, 2, 96000);
    pair(32767, -32768);
    pair(0, 0);
    pair(-32768, -32768);
    pair(100, 200);
    pair(1, 1);
    push_sample(16'sd5, 1'b1);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd2, 1'b0);
    push_sample(16'sd3, 1'b1);
    pair(0, 5);
    settle();
    set_config({CFG_DATA_W{1'b1}}, 2, 1000);
    pair(-32768, -32768);
    repeat (4) pair(0, 0);

    // Frame length settings that can never match
    settle();
    write_reg(CFG_FRAME_LENGTH, CFG_DATA_W'(1));
    push_sample(16'sd7, 1'b1);
    settle();
    write_reg(CFG_FRAME_LENGTH, CFG_DATA_W'(0));
    pair(7, 7);
    settle();
    write_reg(CFG_FRAME_LENGTH, CFG_DATA_W'(2047));
    pair(3, -3);

    // Sample rate extremes against the centroid test
    settle();
    set_config('0, 3, 0);
    send_frame(3, FK_VOICE);
    settle();
    write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'(131071));
    send_frame(3, FK_VOICE);

    // Random settings, each followed by runs of similar frames to walk the hangover
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      settle();
      if (rand_sent > RANDOM_ITEMS * 85 / 100) idle_en = 1'b0;
      else idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       thr = '0;
        1:       thr = CFG_DATA_W'($urandom());
        2:       thr = CFG_DATA_W'(1 << 30);
        default: thr = CFG_DATA_W'($urandom_range(0, 1 << 24));
      endcase
      case ($urandom_range(0, 9))
        0:       flen = 2;
        1:       flen = $urandom_range(25, 64);
        default: flen = $urandom_range(3, 24);
      endcase
      case ($urandom_range(0, 5))
        0:       srate = 1000;
        1:       srate = 96000;
        default: srate = $urandom_range(1000, 96000);
      endcase
      set_config(thr, flen, srate);
      nframes = $urandom_range(8, 16);
      run_left = 0;
      kind = FK_VOICE;
      for (int f = 0; f < nframes && rand_sent < RANDOM_ITEMS; f++) begin
        if (run_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: kind = FK_VOICE;
            5, 6:          kind = FK_QUIET;
            7:             kind = FK_HISS;
            8:             kind = FK_FADE;
            default:       kind = FK_WILD;
          endcase
          run_left = $urandom_range(1, 6);
        end
        n = flen;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, flen + 3);
        send_frame(n, kind);
        rand_sent += n;
        run_left--;
      end
    end

    // Drain with a bound, then allow the pipeline to go quiet
    in_valid = 1'b0;
    for (int w = 0; w < 2000 && pending != 0; w++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (pending != 0) $display("%0t: %0d frame decisions never arrived", $time, pending);

    $display("Covered %0d samples and %0d frame decisions across %0d register settings,",
             samples_sent, frames_checked, settings_used);
    $display("with stalls on both channels and a stall-free tail.");
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("%0t: run timed out", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fvad_pkg.sv
rtl/core/fvad_ctrl.sv
rtl/core/fvad_datapath.sv
rtl/core/frame_voice_activity_detector.sv
bench/fvad_frame_checker.sv
bench/frame_voice_activity_detector_tb.sv
